@@ hdl/crcfr_pkg.sv @@
// Shared types, constants and CRC helpers of the CRC-checked frame receiver.
// Used by the front end, the command queue, the back end and the top level.
`default_nettype none

package crcfr_pkg;

    // Field and register widths.
    localparam int SLOW_W    = 21;
    localparam int FAST_W    = 16;
    localparam int IDLE_W    = 20;
    localparam int LEN_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 21;
    localparam int TDATA_W   = 24;

    // Default depth of the queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    // Register reset values and limits.
    localparam logic [SLOW_W-1:0] SLOW_TIMEOUT_RST = 21'd524288;
    localparam logic [FAST_W-1:0] FAST_TIMEOUT_RST = 16'd2048;
    localparam logic [IDLE_W-1:0] IDLE_MAX         = 20'hFFFFF;
    localparam logic [31:0]       CRC32_POLY       = 32'hEDB88320;
    localparam logic [31:0]       CRC32_INIT       = 32'hFFFFFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_TIMEOUT = 2'd1;

    // Receive phase of the frame parser.
    typedef enum logic [1:0] {
        PH_HEAD0,
        PH_HEAD1,
        PH_BODY
    } t_phase;

    // Frame status reported on the last beat.
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_HDR_TIMEOUT  = 3'd1,
        ST_HDR_CRC      = 3'd2,
        ST_BODY_TIMEOUT = 3'd3,
        ST_CRC_FAIL     = 3'd4
    } t_status;

    // Kind of work handed from the front end to the back end.
    typedef enum logic [2:0] {
        CMD_ADDR,
        CMD_DATA,
        CMD_HDR_TIMEOUT,
        CMD_HDR_CRC,
        CMD_BODY_TIMEOUT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [7:0]       data;
        logic             last;
        logic [LEN_W-1:0] len;
    } t_cmd;

    // Nibble-wise 4-bit CRC table.
    localparam logic [3:0] NIB_TABLE [16] = '{
        4'h0, 4'h7, 4'hE, 4'h9, 4'hB, 4'hC, 4'h5, 4'h2,
        4'h1, 4'h6, 4'hF, 4'h8, 4'hA, 4'hD, 4'h4, 4'h3
    };

    // Header CRC over H0 low, H0 high, H1 low, H1 high nibbles; zero when good.
    function automatic logic [3:0] crc4_header(input logic [7:0] h0, input logic [7:0] h1);
        logic [3:0] c;
        c = 4'h0;
        c = NIB_TABLE[c ^ h0[3:0]];
        c = NIB_TABLE[c ^ h0[7:4]];
        c = NIB_TABLE[c ^ h1[3:0]];
        c = NIB_TABLE[c ^ h1[7:4]];
        return c;
    endfunction

    // One byte of the reflected CRC-32, bit by bit.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/crcfr_front.sv @@
// Front end of the frame receiver: idle timeouts, header parsing and CRC-4,
// and the configuration registers. Emits commands for the back end.
// Depends on crcfr_pkg.
`default_nettype none

module crcfr_front (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [crcfr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [crcfr_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire                                  i_beat_valid,
    output logic                                 o_beat_ready,
    input  wire                                  i_byte_valid,
    input  wire  [7:0]                           i_rx_byte,
    output logic                                 o_cmd_valid,
    output crcfr_pkg::t_cmd                      o_cmd,
    input  wire                                  i_cmd_ready
);

    crcfr_pkg::t_phase                   r_phase, n_phase;
    logic [7:0]                          r_first, n_first;
    logic [crcfr_pkg::IDLE_W-1:0]        r_idle, n_idle;
    logic [crcfr_pkg::LEN_W-1:0]         r_left, n_left;
    logic [crcfr_pkg::LEN_W-1:0]         r_flen, n_flen;
    logic [crcfr_pkg::SLOW_W-1:0]        r_slow;
    logic [crcfr_pkg::FAST_W-1:0]        r_fast;

    logic                                accept;
    logic [crcfr_pkg::IDLE_W:0]          idle_next;
    logic [crcfr_pkg::SLOW_W-1:0]        limit;
    logic [crcfr_pkg::LEN_W-1:0]         plen;
    logic [crcfr_pkg::LEN_W-1:0]         flen;
    logic [crcfr_pkg::LEN_W-1:0]         left_dec;
    logic [3:0]                          hdr_crc;

    assign o_beat_ready = i_cmd_ready;
    assign accept       = i_beat_valid && i_cmd_ready;

    // Configuration registers; high bits of a fast-timeout write are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow <= crcfr_pkg::SLOW_TIMEOUT_RST;
            r_fast <= crcfr_pkg::FAST_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == crcfr_pkg::CFG_SLOW_TIMEOUT) begin
                r_slow <= i_cfg_data[crcfr_pkg::SLOW_W-1:0];
            end else if (i_cfg_index == crcfr_pkg::CFG_FAST_TIMEOUT) begin
                r_fast <= i_cfg_data[crcfr_pkg::FAST_W-1:0];
            end
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= crcfr_pkg::PH_HEAD0;
            r_first <= 8'd0;
            r_idle  <= '0;
            r_left  <= '0;
            r_flen  <= '0;
        end else begin
            r_phase <= n_phase;
            r_first <= n_first;
            r_idle  <= n_idle;
            r_left  <= n_left;
            r_flen  <= n_flen;
        end
    end

    // Header decode helpers.
    assign idle_next = {1'b0, r_idle} + 21'd1;
    assign limit     = (r_phase == crcfr_pkg::PH_HEAD0) ? r_slow
                                                        : {5'd0, r_fast};
    assign plen      = {i_rx_byte[3:0], r_first[7:6]};
    assign flen      = (plen >= 6'd3) ? (plen - 6'd3) : 6'd0;
    assign left_dec  = r_left - 6'd1;
    assign hdr_crc   = crcfr_pkg::crc4_header(r_first, i_rx_byte);

    // Next state and command for each accepted beat.
    always_comb begin
        n_phase     = r_phase;
        n_first     = r_first;
        n_idle      = r_idle;
        n_left      = r_left;
        n_flen      = r_flen;
        o_cmd_valid = 1'b0;
        o_cmd.kind  = crcfr_pkg::CMD_DATA;
        o_cmd.data  = 8'd0;
        o_cmd.last  = 1'b0;
        o_cmd.len   = '0;
        if (accept) begin
            if (!i_byte_valid) begin
                if (idle_next >= limit) begin
                    // Timeout ends the frame.
                    o_cmd_valid = 1'b1;
                    o_cmd.last  = 1'b1;
                    if (r_phase == crcfr_pkg::PH_BODY) begin
                        o_cmd.kind = crcfr_pkg::CMD_BODY_TIMEOUT;
                        o_cmd.len  = r_flen;
                    end else begin
                        o_cmd.kind = crcfr_pkg::CMD_HDR_TIMEOUT;
                    end
                    n_phase = crcfr_pkg::PH_HEAD0;
                    n_idle  = '0;
                end else begin
                    n_idle = idle_next[crcfr_pkg::IDLE_W] ? crcfr_pkg::IDLE_MAX
                                                          : idle_next[crcfr_pkg::IDLE_W-1:0];
                end
            end else begin
                n_idle = '0;
                case (r_phase)
                    crcfr_pkg::PH_HEAD0: begin
                        n_first = i_rx_byte;
                        n_phase = crcfr_pkg::PH_HEAD1;
                    end
                    crcfr_pkg::PH_HEAD1: begin
                        o_cmd_valid = 1'b1;
                        if (hdr_crc != 4'd0) begin
                            o_cmd.kind = crcfr_pkg::CMD_HDR_CRC;
                            o_cmd.last = 1'b1;
                            n_phase    = crcfr_pkg::PH_HEAD0;
                        end else begin
                            n_flen     = flen;
                            n_left     = plen;
                            o_cmd.kind = crcfr_pkg::CMD_ADDR;
                            o_cmd.data = {2'b00, r_first[5:0]};
                            if (plen == 6'd0) begin
                                o_cmd.last = 1'b1;
                                o_cmd.len  = flen;
                                n_phase    = crcfr_pkg::PH_HEAD0;
                            end else begin
                                n_phase = crcfr_pkg::PH_BODY;
                            end
                        end
                    end
                    crcfr_pkg::PH_BODY: begin
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = crcfr_pkg::CMD_DATA;
                        o_cmd.data  = i_rx_byte;
                        n_left      = left_dec;
                        if (left_dec == 6'd0) begin
                            o_cmd.last = 1'b1;
                            o_cmd.len  = r_flen;
                            n_phase    = crcfr_pkg::PH_HEAD0;
                        end
                    end
                    default: begin
                        n_phase = crcfr_pkg::PH_HEAD0;
                    end
                endcase
            end
        end
    end

    // A frame-ending command always returns the parser to the first header byte.
    a_last_to_head0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_valid && o_cmd.last) |=> (r_phase == crcfr_pkg::PH_HEAD0))
        else $error("front: frame end did not return to header phase");

    // An address beat that opens a payload moves the parser into the body.
    a_addr_to_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_valid && o_cmd.kind == crcfr_pkg::CMD_ADDR && !o_cmd.last)
        |=> (r_phase == crcfr_pkg::PH_BODY && r_left != 6'd0))
        else $error("front: address beat did not open the payload");

endmodule

`default_nettype wire

@@ hdl/crcfr_queue.sv @@
// Small register FIFO of commands between the front end and the back end.
// Depends on crcfr_pkg for the command type.
`default_nettype none

module crcfr_queue #(
    parameter int DEPTH = crcfr_pkg::QUEUE_DEPTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  crcfr_pkg::t_cmd      i_data,
    output logic                 o_not_full,
    input  wire                  i_pop,
    output crcfr_pkg::t_cmd      o_data,
    output logic                 o_not_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    crcfr_pkg::t_cmd  r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_not_full  = (r_count != FULL_CNT);
    assign o_not_empty = (r_count != '0);
    assign o_data      = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // No push into a full queue, no pop from an empty one.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_not_full) && !(i_pop && !o_not_empty))
        else $error("queue: overflow or underflow");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue: fill count out of range");

endmodule

`default_nettype wire

@@ hdl/crcfr_back.sv @@
// Back end of the frame receiver: running CRC-32, status and the output
// register toward the result stream. Depends on crcfr_pkg.
`default_nettype none

module crcfr_back (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cmd_valid,
    input  crcfr_pkg::t_cmd                      i_cmd,
    output logic                                 o_cmd_ready,
    output logic                                 o_tvalid,
    input  wire                                  i_tready,
    output logic [crcfr_pkg::TDATA_W-1:0]        o_tdata,
    output logic                                 o_tuser,
    output logic                                 o_tlast
);

    logic [31:0]                     r_crc;
    logic                            r_valid;
    logic                            r_out_valid;
    logic [7:0]                      r_byte;
    logic                            r_last;
    crcfr_pkg::t_status              r_status;
    logic [crcfr_pkg::LEN_W-1:0]     r_len;

    logic                            pop;
    logic                            is_byte;
    logic [31:0]                     crc_seed;
    logic [31:0]                     crc_new;
    crcfr_pkg::t_status              n_status;
    logic [crcfr_pkg::LEN_W-1:0]     n_len;

    assign pop         = i_cmd_valid && (!r_valid || i_tready);
    assign o_cmd_ready = pop;
    assign is_byte     = (i_cmd.kind == crcfr_pkg::CMD_ADDR) ||
                         (i_cmd.kind == crcfr_pkg::CMD_DATA);

    // Byte-wide CRC-32 step; the address byte restarts it.
    assign crc_seed = (i_cmd.kind == crcfr_pkg::CMD_ADDR) ? crcfr_pkg::CRC32_INIT : r_crc;
    assign crc_new  = crcfr_pkg::crc32_byte(crc_seed, i_cmd.data);

    // Status and length of the result.
    always_comb begin
        n_status = crcfr_pkg::ST_OK;
        n_len    = '0;
        case (i_cmd.kind)
            crcfr_pkg::CMD_ADDR, crcfr_pkg::CMD_DATA: begin
                if (i_cmd.last) begin
                    n_status = (crc_new != 32'd0) ? crcfr_pkg::ST_CRC_FAIL : crcfr_pkg::ST_OK;
                    n_len    = i_cmd.len;
                end
            end
            crcfr_pkg::CMD_HDR_TIMEOUT:  n_status = crcfr_pkg::ST_HDR_TIMEOUT;
            crcfr_pkg::CMD_HDR_CRC:      n_status = crcfr_pkg::ST_HDR_CRC;
            crcfr_pkg::CMD_BODY_TIMEOUT: begin
                n_status = crcfr_pkg::ST_BODY_TIMEOUT;
                n_len    = i_cmd.len;
            end
            default: n_status = crcfr_pkg::ST_OK;
        endcase
    end

    // Running CRC and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= crcfr_pkg::CRC32_INIT;
            r_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_valid <= 1'b1;
                if (is_byte) begin
                    r_crc <= crc_new;
                end
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_valid <= is_byte;
            r_byte      <= is_byte ? i_cmd.data : 8'd0;
            r_last      <= i_cmd.last;
            r_status    <= n_status;
            r_len       <= n_len;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tuser  = r_out_valid;
    assign o_tlast  = r_last;
    assign o_tdata  = {7'd0, r_len, r_status, r_byte};

    // A result without a frame byte is always a failed frame end.
    a_error_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_out_valid) |-> (r_last && r_status != crcfr_pkg::ST_OK))
        else $error("back: byte-less result without error status");

endmodule

`default_nettype wire

@@ hdl/crc_checked_frame_receiver_core.sv @@
// Top level of the CRC-checked frame receiver: front end, command queue and
// back end. Depends on crcfr_pkg, crcfr_front, crcfr_queue and crcfr_back.
// Path: a beat that causes a result is written into the queue when it is accepted
// and reaches the result stream through the back-end output register.
// Throughput: one beat per cycle while the queue is not full; the byte-wide CRC-32
// step in the back end and the header CRC-4 in the front end are combinational.
// Reset: synchronous, active low; restores the timeout registers to their
// defaults, returns the parser to the first header byte and empties the queue.
`default_nettype none

module crc_checked_frame_receiver_core #(
    parameter int QUEUE_DEPTH = crcfr_pkg::QUEUE_DEPTH
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [crcfr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [crcfr_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [7:0]                           s_axis_tdata,  // [7:0] rx_byte
    input  wire  [0:0]                           s_axis_tuser,  // [0] byte_valid
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // [7:0] out_byte, [10:8] status, [16:11] frame_length, [23:17] zero
    output logic [crcfr_pkg::TDATA_W-1:0]        m_axis_tdata,
    output logic [0:0]                           m_axis_tuser,  // [0] out_valid
    output logic                                 m_axis_tlast
);

    logic            front_cmd_valid;
    crcfr_pkg::t_cmd front_cmd;
    logic            queue_not_full;
    logic            queue_not_empty;
    crcfr_pkg::t_cmd queue_cmd;
    logic            back_pop;
    logic            back_tuser;

    // Front end: timeouts and header parsing.
    crcfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_beat_valid (s_axis_tvalid),
        .o_beat_ready (s_axis_tready),
        .i_byte_valid (s_axis_tuser[0]),
        .i_rx_byte    (s_axis_tdata),
        .o_cmd_valid  (front_cmd_valid),
        .o_cmd        (front_cmd),
        .i_cmd_ready  (queue_not_full)
    );

    // Command queue between the two halves.
    crcfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_cmd_valid),
        .i_data      (front_cmd),
        .o_not_full  (queue_not_full),
        .i_pop       (back_pop),
        .o_data      (queue_cmd),
        .o_not_empty (queue_not_empty)
    );

    // Back end: CRC-32 check and result register.
    crcfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_not_empty),
        .i_cmd       (queue_cmd),
        .o_cmd_ready (back_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (back_tuser),
        .o_tlast     (m_axis_tlast)
    );

    assign m_axis_tuser = back_tuser;

endmodule

`default_nettype wire
